// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the color classify block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LCCRD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition must never be true outside reset.
`define LCCRD_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// File: rtl/core/lccrd_pkg.sv
`timescale 1ns / 1ps
// Package for the LUT color classify and run detect block.
// Types, constants and the table index helper; no dependencies.
package lccrd_pkg;

  localparam int DefaultMaxCols = 2048;
  localparam int DefaultMaxRows = 2048;
  localparam int TableDepth     = 512;
  localparam int IdxW           = $clog2(TableDepth);
  localparam int CodeW          = 8;
  localparam int ChanW          = 8;
  localparam int PosW           = 11;
  localparam int NumSlots       = 3;
  localparam int CntW           = 2;

  typedef enum logic {
    OpClassify = 1'b0,
    OpTableWr  = 1'b1
  } op_e;

  typedef enum logic {
    KindPixel = 1'b0,
    KindRun   = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [CodeW-1:0] color_code;
    logic             is_match;
    logic [PosW-1:0]  run_row;
    logic [PosW-1:0]  run_begin;
    logic [PosW-1:0]  run_end;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [CntW-1:0]           count;
    res_t [NumSlots-1:0]       slot;
  } res_set_t;

  // Top three bits of each channel, red high, blue low.
  function automatic logic [IdxW-1:0] table_index(logic [ChanW-1:0] r,
                                                  logic [ChanW-1:0] g,
                                                  logic [ChanW-1:0] b);
    return {r[ChanW-1 -: 3], g[ChanW-1 -: 3], b[ChanW-1 -: 3]};
  endfunction

endpackage

// File: rtl/core/lccrd_table.sv
`timescale 1ns / 1ps
// Color code table: 512 x 8 synchronous memory with a registered read.
// Clears itself after reset, one entry per cycle. Depends on lccrd_pkg.
module lccrd_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [lccrd_pkg::IdxW-1:0] rd_idx_i,
  input  logic                       wr_en_i,
  input  logic [lccrd_pkg::IdxW-1:0] wr_idx_i,
  input  logic [lccrd_pkg::CodeW-1:0] wr_data_i,
  output logic [lccrd_pkg::CodeW-1:0] rd_data_o,
  output logic                       busy_o
);
  import lccrd_pkg::*;

  logic [CodeW-1:0] code_mem_q [TableDepth];
  logic [CodeW-1:0] rd_data_q;
  logic             clr_busy_q;
  logic [IdxW-1:0]  clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == IdxW'(TableDepth - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      code_mem_q[clr_idx_q] <= '0;
    end else if (wr_en_i) begin
      code_mem_q[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= code_mem_q[rd_idx_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

// File: rtl/core/lccrd_track.sv
`timescale 1ns / 1ps
// Run tracking stage: takes the table code, keeps row, column and run state,
// and builds the set of up to three results per pixel. Depends on lccrd_pkg.
module lccrd_track #(
  parameter int MaxCols = lccrd_pkg::DefaultMaxCols,
  parameter int MaxRows = lccrd_pkg::DefaultMaxRows
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  input  logic                        first_of_frame_i,
  input  logic                        end_of_row_i,
  input  logic [lccrd_pkg::CodeW-1:0] code_i,
  input  logic [lccrd_pkg::CodeW-1:0] target_i,
  output logic                        take_ready_o,
  output logic                        set_valid_o,
  input  logic                        set_ready_i,
  output lccrd_pkg::res_set_t         set_o
);
  import lccrd_pkg::*;

  localparam int ColW = $clog2(MaxCols);
  localparam int RowW = (MaxRows > 1) ? $clog2(MaxRows) : 1;

  function automatic logic [PosW-1:0] col_pos(logic [ColW-1:0] c);
    logic [ColW+PosW-1:0] w;
    w = {{PosW{1'b0}}, c};
    return w[PosW-1:0];
  endfunction

  function automatic logic [PosW-1:0] row_pos(logic [RowW-1:0] r);
    logic [RowW+PosW-1:0] w;
    w = {{PosW{1'b0}}, r};
    return w[PosW-1:0];
  endfunction

  logic            s1_valid_q;
  logic            sof_q, eor_q;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic            open_q, open_d;
  logic            prev_q, prev_d;
  logic [ColW-1:0] first_q, first_d;
  logic [ColW-1:0] lastm_q, lastm_d;

  logic            fire;
  logic [RowW-1:0] row_c;
  logic [ColW-1:0] col_c;
  logic            open_c, prev_c, match, gap_seg, eor_seg, open_m;
  logic [CntW-1:0] count;
  res_t            pix, seg_a, seg_b;

  assign fire         = s1_valid_q && set_ready_i;
  assign take_ready_o = !s1_valid_q || set_ready_i;
  assign set_valid_o  = s1_valid_q;

  always_comb begin
    row_c   = sof_q ? '0 : row_q;
    col_c   = sof_q ? '0 : col_q;
    open_c  = sof_q ? 1'b0 : open_q;
    prev_c  = sof_q ? 1'b0 : prev_q;
    match   = (code_i == target_i);
    gap_seg = match && open_c && !prev_c;
    first_d = (match && (!open_c || !prev_c)) ? col_c : first_q;
    lastm_d = match ? col_c : lastm_q;
    open_m  = open_c || match;
    eor_seg = eor_q && open_m;
    count   = CntW'(1) + CntW'(gap_seg) + CntW'(eor_seg);

    if (eor_q) begin
      open_d = 1'b0;
      prev_d = 1'b0;
      col_d  = '0;
      row_d  = (row_c == RowW'(MaxRows - 1)) ? '0 : row_c + 1'b1;
    end else begin
      open_d = open_m;
      prev_d = match;
      col_d  = (col_c == ColW'(MaxCols - 1)) ? '0 : col_c + 1'b1;
      row_d  = row_c;
    end

    pix            = '0;
    pix.kind       = KindPixel;
    pix.color_code = code_i;
    pix.is_match   = match;
    pix.last       = (count == CntW'(1));

    seg_a           = '0;
    seg_a.kind      = KindRun;
    seg_a.run_row   = row_pos(row_c);
    seg_a.run_begin = col_pos(first_q);
    seg_a.run_end   = col_pos(lastm_q);

    seg_b           = '0;
    seg_b.kind      = KindRun;
    seg_b.run_row   = row_pos(row_c);
    seg_b.run_begin = col_pos(first_d);
    seg_b.run_end   = col_pos(lastm_d);

    set_o.count     = count;
    set_o.slot[0]   = pix;
    set_o.slot[1]   = gap_seg ? seg_a : seg_b;
    set_o.slot[1].last = (count == CntW'(2));
    set_o.slot[2]   = seg_b;
    set_o.slot[2].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      row_q      <= '0;
      col_q      <= '0;
      open_q     <= 1'b0;
      prev_q     <= 1'b0;
      first_q    <= '0;
      lastm_q    <= '0;
    end else begin
      if (item_valid_i) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        row_q   <= row_d;
        col_q   <= col_d;
        open_q  <= open_d;
        prev_q  <= prev_d;
        first_q <= first_d;
        lastm_q <= lastm_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid_i) begin
      sof_q <= first_of_frame_i;
      eor_q <= end_of_row_i;
    end
  end

endmodule

// File: rtl/core/lccrd_outbuf.sv
`timescale 1ns / 1ps
// Output buffer: holds one result set of up to three entries and hands them
// out one per transaction. Depends on lccrd_pkg.
module lccrd_outbuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                set_valid_i,
  input  lccrd_pkg::res_set_t set_i,
  output logic                set_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lccrd_pkg::res_t     res_o
);
  import lccrd_pkg::*;

  res_t [NumSlots-1:0] slot_q;
  logic [CntW-1:0]     rem_q;
  logic [CntW-1:0]     pos_q;
  logic                load, pop;

  assign out_valid_o = (rem_q != '0);
  assign set_ready_o = (rem_q == '0) || ((rem_q == CntW'(1)) && out_ready_i);
  assign load        = set_valid_i && set_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign res_o       = slot_q[pos_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      pos_q <= '0;
    end else if (load) begin
      rem_q <= set_i.count;
      pos_q <= '0;
    end else if (pop) begin
      rem_q <= rem_q - 1'b1;
      pos_q <= pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      slot_q <= set_i.slot;
    end
  end

endmodule

// File: rtl/core/lut_color_classify_run_detect.sv
`timescale 1ns / 1ps
// LUT color classify and run detect, top level.
// Uses lccrd_pkg, lccrd_table, lccrd_track, lccrd_outbuf, assert_macros.svh.
//
// Input channel (in_valid_i / in_ready_o): one transaction per pixel or table
// write, op_i selects. A table write stores lut_code_i at the entry picked by
// the top three bits of red, green and blue and yields no result.
// Output channel (out_valid_o / out_ready_i): one result per transaction; a
// pixel yields its classification, then up to two run segments; last_o marks
// the final result of a pixel.
// Path: a pixel's code is read from the table into a register, then run tracking
// builds its results into the output buffer, which offers the first of them.
// Throughput: one pixel per cycle when each pixel yields one result and out_ready_i
// stays high; a pixel with n results occupies the output buffer for n transactions.
// Reset: counters and run state clear at once; the table is then cleared over
// all 512 entries, one entry per cycle, with in_ready_o low. target_q resets to
// 0; users write it via cfg_we_i / cfg_wdata_i only while idle (block does not check).
// Stall: a held output keeps the tracking stage full; input is then refused
// once the stage holding the next pixel is occupied.
module lut_color_classify_run_detect #(
  parameter int MaxCols = lccrd_pkg::DefaultMaxCols,
  parameter int MaxRows = lccrd_pkg::DefaultMaxRows
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lccrd_pkg::CodeW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [lccrd_pkg::ChanW-1:0] red_i,
  input  logic [lccrd_pkg::ChanW-1:0] green_i,
  input  logic [lccrd_pkg::ChanW-1:0] blue_i,
  input  logic [lccrd_pkg::CodeW-1:0] lut_code_i,
  input  logic                        first_of_frame_i,
  input  logic                        end_of_row_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        kind_o,
  output logic [lccrd_pkg::CodeW-1:0] color_code_o,
  output logic                        is_match_o,
  output logic [lccrd_pkg::PosW-1:0]  run_row_o,
  output logic [lccrd_pkg::PosW-1:0]  run_begin_o,
  output logic [lccrd_pkg::PosW-1:0]  run_end_o,
  output logic                        last_o
);
  import lccrd_pkg::*;
  `include "assert_macros.svh"

  logic [CodeW-1:0] target_q;
  logic             tbl_busy, take_ready, accept, rd_en, wr_en;
  logic [IdxW-1:0]  idx;
  logic [CodeW-1:0] code;
  logic             set_valid, set_ready;
  res_set_t         set;
  res_t             res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = !tbl_busy && take_ready;
  assign accept     = in_valid_i && in_ready_o;
  assign wr_en      = accept && (op_e'(op_i) == OpTableWr);
  assign rd_en      = accept && (op_e'(op_i) == OpClassify);
  assign idx        = table_index(red_i, green_i, blue_i);

  lccrd_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_idx_i  (idx),
    .wr_en_i   (wr_en),
    .wr_idx_i  (idx),
    .wr_data_i (lut_code_i),
    .rd_data_o (code),
    .busy_o    (tbl_busy)
  );

  lccrd_track #(
    .MaxCols (MaxCols),
    .MaxRows (MaxRows)
  ) u_track (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (rd_en),
    .first_of_frame_i (first_of_frame_i),
    .end_of_row_i     (end_of_row_i),
    .code_i           (code),
    .target_i         (target_q),
    .take_ready_o     (take_ready),
    .set_valid_o      (set_valid),
    .set_ready_i      (set_ready),
    .set_o            (set)
  );

  lccrd_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .set_valid_i (set_valid),
    .set_i       (set),
    .set_ready_o (set_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign kind_o       = res.kind;
  assign color_code_o = res.color_code;
  assign is_match_o   = res.is_match;
  assign run_row_o    = res.run_row;
  assign run_begin_o  = res.run_begin;
  assign run_end_o    = res.run_end;
  assign last_o       = res.last;

  `LCCRD_NEVER(a_no_accept_in_clear, clk_i, rst_ni, tbl_busy && in_ready_o, "input taken during table clear")
  `LCCRD_NEVER(a_no_output_in_clear, clk_i, rst_ni, tbl_busy && out_valid_o, "result offered during table clear")
  `LCCRD_ASSERT(a_pixel_no_run, clk_i, rst_ni, (out_valid_o && (kind_o == KindPixel)) |-> ((run_row_o == '0) && (run_begin_o == '0) && (run_end_o == '0)), "pixel result carries run fields")
  `LCCRD_ASSERT(a_run_no_code, clk_i, rst_ni, (out_valid_o && (kind_o == KindRun)) |-> ((color_code_o == '0) && !is_match_o), "run segment carries pixel fields")

endmodule

// File: dv/lut_color_classify_run_detect_tb.sv
`timescale 1ns / 1ps
// Testbench for lut_color_classify_run_detect: table writes, pixel classification
// and run segments, checked against a predictor kept inside the bench.
// Depends on lccrd_pkg and the RTL of the block only.
module lut_color_classify_run_detect_tb;
  import lccrd_pkg::*;

  localparam int Cols = DefaultMaxCols;
  localparam int Rows = DefaultMaxRows;

  typedef struct {
    op_e              op;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [CodeW-1:0] lut_code;
    logic             first_of_frame;
    logic             end_of_row;
  } pixel_t;

  class color_run_board;
    logic [CodeW-1:0] codes [TableDepth];
    logic [CodeW-1:0] target;
    logic [PosW-1:0]  row_at, col_at, run_from, run_to;
    logic             run_open, prev_hit;
    res_t             owed [$];
    int               errors, checked, pixels, writes, segments, targets;

    function new();
      foreach (codes[i]) codes[i] = '0;
      target   = '0;
      row_at   = '0;
      col_at   = '0;
      run_from = '0;
      run_to   = '0;
      run_open = 1'b0;
      prev_hit = 1'b0;
    endfunction

    task report_mismatch(string msg);
      if (errors < 40) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function res_t segment(logic [PosW-1:0] row, logic [PosW-1:0] from, logic [PosW-1:0] to);
      res_t s;
      s           = '0;
      s.kind      = KindRun;
      s.run_row   = row;
      s.run_begin = from;
      s.run_end   = to;
      segments++;
      return s;
    endfunction

    function void record_item(pixel_t t);
      logic [IdxW-1:0]  idx;
      logic [CodeW-1:0] code;
      logic [PosW-1:0]  row, col;
      logic             hit;
      res_t             outs [NumSlots];
      int               n;
      idx = {t.red[ChanW-1 -: 3], t.green[ChanW-1 -: 3], t.blue[ChanW-1 -: 3]};
      if (t.op == OpTableWr) begin
        codes[idx] = t.lut_code;
        writes++;
        return;
      end
      pixels++;
      if (t.first_of_frame) begin
        row_at   = '0;
        col_at   = '0;
        run_open = 1'b0;
        prev_hit = 1'b0;
      end
      row = row_at;
      col = col_at;
      code = codes[idx];
      hit = (code == target);
      outs[0]            = '0;
      outs[0].kind       = KindPixel;
      outs[0].color_code = code;
      outs[0].is_match   = hit;
      n = 1;
      if (hit) begin
        if (!run_open) begin
          run_open = 1'b1;
          run_from = col;
        end else if (!prev_hit) begin
          outs[n] = segment(row, run_from, run_to);
          n++;
          run_from = col;
        end
        run_to = col;
      end
      prev_hit = hit;
      if (t.end_of_row) begin
        if (run_open) begin
          outs[n] = segment(row, run_from, run_to);
          n++;
        end
        run_open = 1'b0;
        prev_hit = 1'b0;
        col_at   = '0;
        row_at   = (int'(row) + 1 >= Rows) ? '0 : row + 1'b1;
      end else begin
        col_at = (int'(col) + 1 >= Cols) ? '0 : col + 1'b1;
      end
      outs[n-1].last = 1'b1;
      for (int k = 0; k < n; k++) owed.push_back(outs[k]);
    endfunction

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want)
        report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                  checked, name, got, want));
    endtask

    task compare_result(res_t got);
      res_t want;
      checked++;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("result %0d (kind %0d) arrived with nothing outstanding",
                                  checked, got.kind));
        return;
      end
      want = owed.pop_front();
      compare_field("kind", got.kind, want.kind);
      compare_field("color_code", got.color_code, want.color_code);
      compare_field("is_match", got.is_match, want.is_match);
      compare_field("run_row", got.run_row, want.run_row);
      compare_field("run_begin", got.run_begin, want.run_begin);
      compare_field("run_end", got.run_end, want.run_end);
      compare_field("last", got.last, want.last);
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CodeW-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             op_i;
  logic [ChanW-1:0] red_i, green_i, blue_i;
  logic [CodeW-1:0] lut_code_i;
  logic             first_of_frame_i, end_of_row_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             kind_o;
  logic [CodeW-1:0] color_code_o;
  logic             is_match_o;
  logic [PosW-1:0]  run_row_o, run_begin_o, run_end_o;
  logic             last_o;

  int tx_idle;
  int rx_idle;

  color_run_board board = new();

  lut_color_classify_run_detect i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .red_i            (red_i),
    .green_i          (green_i),
    .blue_i           (blue_i),
    .lut_code_i       (lut_code_i),
    .first_of_frame_i (first_of_frame_i),
    .end_of_row_i     (end_of_row_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .color_code_o     (color_code_o),
    .is_match_o       (is_match_o),
    .run_row_o        (run_row_o),
    .run_begin_o      (run_begin_o),
    .run_end_o        (run_end_o),
    .last_o           (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= rx_idle);

  initial begin : watch
    res_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.kind       = kind_e'(kind_o);
        got.color_code = color_code_o;
        got.is_match   = is_match_o;
        got.run_row    = run_row_o;
        got.run_begin  = run_begin_o;
        got.run_end    = run_end_o;
        got.last       = last_o;
        board.compare_result(got);
      end
    end
  end

  initial begin : limit
    #3_000_000;
    $display("lut_color_classify_run_detect regression: fail");
    $finish;
  end

  function automatic pixel_t px(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                                logic [ChanW-1:0] b, logic fof, logic eor);
    pixel_t t;
    t.op             = OpClassify;
    t.red            = r;
    t.green          = g;
    t.blue           = b;
    t.lut_code       = CodeW'($urandom);
    t.first_of_frame = fof;
    t.end_of_row     = eor;
    return t;
  endfunction

  function automatic pixel_t wr(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                                logic [ChanW-1:0] b, logic [CodeW-1:0] code,
                                logic fof, logic eor);
    pixel_t t;
    t          = px(r, g, b, fof, eor);
    t.op       = OpTableWr;
    t.lut_code = code;
    return t;
  endfunction

  // Pixel landing on a given table entry, random low bits.
  function automatic pixel_t near(logic [IdxW-1:0] idx, logic fof, logic eor);
    return px({idx[8:6], 5'($urandom)}, {idx[5:3], 5'($urandom)},
              {idx[2:0], 5'($urandom)}, fof, eor);
  endfunction

  task automatic send(pixel_t t);
    while ($urandom_range(99) < tx_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    op_i             <= t.op;
    red_i            <= t.red;
    green_i          <= t.green;
    blue_i           <= t.blue;
    lut_code_i       <= t.lut_code;
    first_of_frame_i <= t.first_of_frame;
    end_of_row_i     <= t.end_of_row;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.record_item(t);
    @(negedge clk_i);
  endtask

  // Stop sending, let every owed result arrive, then cover pipeline latency.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.owed.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic set_target(logic [CodeW-1:0] code);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= code;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.target = code;
    board.targets++;
  endtask

  // Rows of pixels drawn mostly from a small palette of table entries, mixed with table writes.
  task automatic random_rows(int budget, bit hold_once);
    logic [IdxW-1:0]  palette [4];
    logic [IdxW-1:0]  idx;
    logic [CodeW-1:0] code;
    pixel_t           t;
    int               sent, row_len, pick;
    for (int k = 0; k < 4; k++) begin
      palette[k] = IdxW'($urandom);
      code = (k < 2) ? board.target : (k == 2) ? CodeW'($urandom) : board.target ^ 8'h01;
      t = near(palette[k], 1'($urandom), 1'($urandom));
      t.op = OpTableWr;
      t.lut_code = code;
      send(t);
    end
    sent = 4;
    while (sent < budget) begin
      row_len = $urandom_range(1, 8);
      for (int pos = 0; pos < row_len && sent < budget; pos++) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          idx = palette[$urandom_range(3)];
          t = near(idx, 1'($urandom), 1'($urandom));
          t.op = OpTableWr;
          t.lut_code = $urandom_range(1) ? board.target : CodeW'($urandom);
        end else if (pick < 30) begin
          t = px(ChanW'($urandom), ChanW'($urandom), ChanW'($urandom),
                 $urandom_range(19) == 0, $urandom_range(3) == 0);
        end else begin
          t = near(palette[$urandom_range(3)], pos == 0 && $urandom_range(9) == 0,
                   pos == row_len - 1);
        end
        if (hold_once && sent == budget / 2) drain();
        send(t);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    op_i             = OpClassify;
    red_i            = '0;
    green_i          = '0;
    blue_i           = '0;
    lut_code_i       = '0;
    first_of_frame_i = 1'b0;
    end_of_row_i     = 1'b0;
    out_ready_i      = 1'b0;
    tx_idle          = 34;
    rx_idle          = 51;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_target(8'hFF);
    send(px(8'h00, 8'h00, 8'h00, 1'b1, 1'b0));          // cleared table, no match
    send(wr(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));   // frame and row flags ignored
    send(wr(8'h1F, 8'h1F, 8'h1F, 8'h00, 1'b0, 1'b0));
    send(wr(8'hA0, 8'h40, 8'h20, 8'h5A, 1'b0, 1'b1));
    send(px(8'hFF, 8'hE0, 8'hF3, 1'b0, 1'b0));          // run opens
    send(px(8'hE7, 8'hFF, 8'hE0, 1'b0, 1'b0));
    send(px(8'h00, 8'h1F, 8'h00, 1'b0, 1'b0));          // gap
    send(px(8'hBF, 8'h5F, 8'h3F, 1'b0, 1'b0));
    send(px(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0));          // gap closes first run
    send(px(8'hF0, 8'hF0, 8'hF0, 1'b0, 1'b1));          // end of row with open run
    send(px(8'hE0, 8'hE0, 8'hE0, 1'b0, 1'b0));
    send(px(8'h10, 8'h20, 8'h30, 1'b0, 1'b0));
    send(px(8'hFE, 8'hFD, 8'hFC, 1'b0, 1'b1));          // pixel, gap segment, row segment
    send(px(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0));
    send(px(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0));
    send(px(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0));          // new frame drops the open run
    send(px(8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
    send(px(8'h7F, 8'h80, 8'h9F, 1'b0, 1'b1));          // row ends with no run
    send(wr(8'h7F, 8'h80, 8'h9F, 8'hFF, 1'b0, 1'b0));
    send(px(8'h60, 8'h9F, 8'h80, 1'b1, 1'b1));          // single pixel frame and row
    drain();

    set_target(8'h00);
    random_rows(27, 1'b1);
    drain();

    tx_idle = 51;
    rx_idle = 34;
    set_target(CodeW'($urandom_range(1, 254)));
    random_rows(27, 1'b0);
    drain();

    tx_idle = 0;
    rx_idle = 0;
    set_target(CodeW'($urandom));
    random_rows(27, 1'b0);
    drain();

    $display("Covered %0d pixels and %0d table writes over %0d target settings,",
             board.pixels, board.writes, board.targets);
    $display("with stalls on both sides; %0d results checked, %0d run segments.",
             board.checked, board.segments);
    if (board.errors == 0) begin
      $display("lut_color_classify_run_detect regression: pass");
    end else begin
      $display("lut_color_classify_run_detect regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/lccrd_pkg.sv
rtl/core/lccrd_table.sv
rtl/core/lccrd_track.sv
rtl/core/lccrd_outbuf.sv
rtl/core/lut_color_classify_run_detect.sv
dv/lut_color_classify_run_detect_tb.sv
